### rtl/core/mcsw_pkg.sv
package mcsw_pkg;

    // request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_DONE    = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_RESPAWN = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] client_id;
    } in_item_t;

    typedef struct packed {
        logic       restart_valid;
        logic [3:0] restart_client;
        logic       last_result;
    } out_item_t;

    // scan token control handed from cell to cell
    typedef struct packed {
        logic active;
        logic tick;
        logic found;
    } tok_t;

    // slot write command broadcast to all cells
    typedef struct packed {
        logic start;
        logic clear;
    } cmd_t;

endpackage

### rtl/core/mcsw_cell.sv
module mcsw_cell #(
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      slot,
    input  mcsw_pkg::cmd_t        cmd,
    input  logic [IDX_W-1:0]      cmd_idx,
    input  logic [STAMP_BITS-1:0] cmd_stamp,
    input  logic                  advance,
    input  mcsw_pkg::tok_t        tok_in,
    input  logic [IDX_W-1:0]      tok_idx_in,
    input  logic [STAMP_BITS-1:0] tok_stamp_in,
    output mcsw_pkg::tok_t        tok_out,
    output logic [IDX_W-1:0]      tok_idx_out,
    output logic [STAMP_BITS-1:0] tok_stamp_out,
    input  logic                  above_in,
    output logic                  above_out,
    output logic                  emit,
    output logic                  emit_last
);
    import mcsw_pkg::*;

    logic                  cur_reg, cur_next;
    logic                  prev_reg, prev_next;
    logic                  sv_reg, sv_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    tok_t                  tok_reg, tok_next;
    logic [IDX_W-1:0]      tok_idx_reg, tok_idx_next;
    logic [STAMP_BITS-1:0] tok_stamp_reg, tok_stamp_next;
    logic                  hit;
    logic                  tick_here;

    assign hit       = (cmd_idx == slot);
    assign tick_here = tok_reg.active && tok_reg.tick;
    assign emit      = tick_here && prev_reg;
    assign emit_last = !above_in;
    assign above_out = prev_reg | above_in;

    // oldest search: keep the smaller stamp, lower slot wins a tie
    always_comb
    begin
        tok_out       = tok_reg;
        tok_idx_out   = tok_idx_reg;
        tok_stamp_out = tok_stamp_reg;
        if (tok_reg.active && !tok_reg.tick && sv_reg)
        begin
            tok_out.found = 1'b1;
            if (!tok_reg.found || (stamp_reg < tok_stamp_reg))
            begin
                tok_idx_out   = slot;
                tok_stamp_out = stamp_reg;
            end
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        sv_next        = sv_reg;
        stamp_next     = stamp_reg;
        tok_next       = advance ? tok_in : tok_reg;
        tok_idx_next   = advance ? tok_idx_in : tok_idx_reg;
        tok_stamp_next = advance ? tok_stamp_in : tok_stamp_reg;
        if (cmd.start && hit)
        begin
            cur_next   = 1'b1;
            sv_next    = 1'b1;
            stamp_next = cmd_stamp;
        end
        if (cmd.clear && hit)
        begin
            cur_next  = 1'b0;
            prev_next = 1'b0;
            sv_next   = 1'b0;
        end
        if (tick_here && advance)
        begin
            if (prev_reg)
            begin
                sv_next = 1'b0;
            end
            prev_next = cur_reg;
            cur_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= 1'b0;
            prev_reg <= 1'b0;
            sv_reg   <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            sv_reg   <= sv_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg     <= stamp_next;
        tok_idx_reg   <= tok_idx_next;
        tok_stamp_reg <= tok_stamp_next;
    end

endmodule

### rtl/core/multi_client_stall_watchdog.sv
// start and done: taken in the cycle they arrive
// period tick: the token walks the cell chain, then ST_FINISH; the chain holds while an emit waits on out_ready
// respawn oldest: the token walks the chain one cell per cycle, then ST_FINISH waits on out_ready
// one request at a time; the cell chain length sets how long tick and respawn take
// reset clears all marks, stamp valid bits, the stamp counter and the output valid flag
module multi_client_stall_watchdog #(
    parameter int CLIENTS    = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcsw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mcsw_pkg::out_item_t out_data
);
    import mcsw_pkg::*;

    localparam int IDX_W = $clog2(CLIENTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [STAMP_BITS-1:0] cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;
    tok_t                  fin_reg, fin_next;
    logic [IDX_W-1:0]      fin_idx_reg, fin_idx_next;

    // broadcast slot command and token launch into the head cell
    cmd_t                  cmd;
    logic [IDX_W-1:0]      cmd_idx;
    tok_t                  launch;

    // chain links: index k of the token arrays is the output of cell k-1; above_chain[k] is the output of cell k
    tok_t                  tok_chain   [1:CLIENTS];
    logic [IDX_W-1:0]      idx_chain   [1:CLIENTS];
    logic [STAMP_BITS-1:0] stamp_chain [1:CLIENTS];
    logic                  above_chain [0:CLIENTS];
    logic [CLIENTS-1:0]    emit_vec;
    logic [CLIENTS-1:0]    last_vec;

    logic                  emit_any;
    logic                  out_free;
    logic                  advance;
    logic                  cid_ok;
    logic [IDX_W-1:0]      hit_idx;
    logic                  hit_last;

    assign above_chain[CLIENTS] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CLIENTS; gi++)
        begin : g_cell
            tok_t                  t_in;
            logic [IDX_W-1:0]      t_idx;
            logic [STAMP_BITS-1:0] t_stamp;

            if (gi == 0)
            begin : g_head
                assign t_in    = launch;
                assign t_idx   = '0;
                assign t_stamp = '0;
            end
            else
            begin : g_link
                assign t_in    = tok_chain[gi];
                assign t_idx   = idx_chain[gi];
                assign t_stamp = stamp_chain[gi];
            end

            mcsw_cell #(
                .STAMP_BITS (STAMP_BITS),
                .IDX_W      (IDX_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .slot          (IDX_W'(gi)),
                .cmd           (cmd),
                .cmd_idx       (cmd_idx),
                .cmd_stamp     (cnt_next),
                .advance       (advance),
                .tok_in        (t_in),
                .tok_idx_in    (t_idx),
                .tok_stamp_in  (t_stamp),
                .tok_out       (tok_chain[gi+1]),
                .tok_idx_out   (idx_chain[gi+1]),
                .tok_stamp_out (stamp_chain[gi+1]),
                .above_in      (above_chain[gi+1]),
                .above_out     (above_chain[gi]),
                .emit          (emit_vec[gi]),
                .emit_last     (last_vec[gi])
            );
        end
    endgenerate

    // a tick result is pending in some cell; the chain holds until the output frees up
    assign emit_any  = |emit_vec;
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = !(emit_any && !out_free);
    assign cid_ok    = (32'(in_data.client_id) < CLIENTS);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // at most one cell holds the token, so the emitting slot is an or of its index
    always_comb
    begin
        hit_idx  = '0;
        hit_last = 1'b0;
        for (int k = 0; k < CLIENTS; k++)
        begin
            if (emit_vec[k])
            begin
                hit_idx  = hit_idx | IDX_W'(k);
                hit_last = hit_last | last_vec[k];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        fin_next       = fin_reg;
        fin_idx_next   = fin_idx_reg;
        cmd            = '0;
        cmd_idx        = IDX_W'(in_data.client_id);
        launch         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_t'(in_data.req_type))
                        REQ_START:
                        begin
                            if (cid_ok)
                            begin
                                // counter wraps; the new value is the client's stamp
                                cnt_next  = cnt_reg + {{(STAMP_BITS-1){1'b0}}, 1'b1};
                                cmd.start = 1'b1;
                            end
                        end
                        REQ_DONE:
                        begin
                            if (cid_ok)
                            begin
                                cmd.clear = 1'b1;
                            end
                        end
                        REQ_TICK:
                        begin
                            launch.active = 1'b1;
                            launch.tick   = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        REQ_RESPAWN:
                        begin
                            launch.active = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // stalled client transfer straight from the cell holding the token
                if (emit_any && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{restart_valid: 1'b1,
                                       restart_client: 4'(hit_idx),
                                       last_result: hit_last};
                end
                if (advance)
                begin
                    fin_next     = tok_chain[CLIENTS];
                    fin_idx_next = idx_chain[CLIENTS];
                    if (tok_chain[CLIENTS].active)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                // respawn result leaves once the token has seen every cell
                if (fin_reg.tick || !fin_reg.found)
                begin
                    fin_next   = '0;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{restart_valid: 1'b1,
                                       restart_client: 4'(fin_idx_reg),
                                       last_result: 1'b1};
                    cmd.clear      = 1'b1;
                    cmd_idx        = fin_idx_reg;
                    fin_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            fin_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        fin_idx_reg  <= fin_idx_next;
    end

endmodule
